FILE: rtl/rmsd_pkg.sv
// ---------------------------------------------------------------------------
// rmsd_pkg
// Shared types and constants of the RGB matrix scan driver: field widths,
// command and register codes, controller/datapath interface structs.
// ---------------------------------------------------------------------------
package rmsd_pkg;

   localparam int COLUMN_W   = 6;
   localparam int PIXEL_X_W  = 7;
   localparam int PIXEL_Y_W  = 6;
   localparam int COLOR_W    = 8;
   localparam int ROW_ADDR_W = 4;
   localparam int CSR_IDX_W  = 2;

   localparam logic CMD_PIXEL_WRITE = 1'b0;
   localparam logic CMD_SCAN        = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PANEL_ENABLE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK_REQUEST = 2'd1;

   typedef struct packed {
      logic clear_wr;
      logic pix_wr;
      logic rd_en;
      logic row_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic col_last;
      logic pipe_busy;
   } dp_status_type;

endpackage

FILE: rtl/rmsd_ram.sv
// ---------------------------------------------------------------------------
// rmsd_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module rmsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rmsd_ctrl.sv
// ---------------------------------------------------------------------------
// rmsd_ctrl
// Controller: frame buffer clear after reset, idle, column scan, drain and
// row step.
// ---------------------------------------------------------------------------
module rmsd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_command,
   input  rmsd_pkg::dp_status_type status,
   output rmsd_pkg::ctrl_cmd_type  cmd,
   output logic                   busy
);

   import rmsd_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start && req_command == CMD_SCAN) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.col_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   always_comb begin
      cmd.clear_wr = (state_ff == ST_CLEAR);
      cmd.pix_wr   = (state_ff == ST_IDLE) && start && (req_command == CMD_PIXEL_WRITE);
      cmd.rd_en    = (state_ff == ST_SCAN);
      cmd.row_step = (state_ff == ST_DRAIN) && !status.pipe_busy;
   end

   assign busy = busy_ff;

endmodule

FILE: rtl/rmsd_datapath.sv
// ---------------------------------------------------------------------------
// rmsd_datapath
// Datapath: banked frame buffer (upper and lower half rows), clear and
// column counters, scan row and gray level, level compare, result register.
// ---------------------------------------------------------------------------
module rmsd_datapath #(
   parameter int PANEL_WIDTH  = 64,
   parameter int PANEL_HEIGHT = 32,
   parameter int LEVEL_STEPS  = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rmsd_pkg::ctrl_cmd_type               cmd,
   output rmsd_pkg::dp_status_type              status,
   input  logic                                csr_valid,
   input  logic [rmsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic                                csr_data,
   input  logic [rmsd_pkg::PIXEL_X_W-1:0]      req_pixel_x,
   input  logic [rmsd_pkg::PIXEL_Y_W-1:0]      req_pixel_y,
   input  logic [rmsd_pkg::COLOR_W-1:0]        req_pixel_color,
   output logic                                rsp_valid,
   output logic [rmsd_pkg::COLUMN_W-1:0]       rsp_column,
   output logic                                rsp_red_upper,
   output logic                                rsp_green_upper,
   output logic                                rsp_blue_upper,
   output logic                                rsp_red_lower,
   output logic                                rsp_green_lower,
   output logic                                rsp_blue_lower,
   output logic [rmsd_pkg::ROW_ADDR_W-1:0]     rsp_row_address,
   output logic                                rsp_latch_last,
   output logic                                rsp_output_enable
);

   import rmsd_pkg::*;

   localparam int HALF_ROWS = (PANEL_HEIGHT / 2 > 0) ? PANEL_HEIGHT / 2 : 1;
   localparam int COL_W     = $clog2(PANEL_WIDTH);
   localparam int ROW_W     = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
   localparam int LVL_W     = $clog2(LEVEL_STEPS);
   localparam int CMP_W     = (LVL_W > 3) ? LVL_W : 3;
   localparam int RAM_DEPTH = HALF_ROWS * (2 ** COL_W);
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic [RAM_AW-1:0] clr_ff, clr_in;
   logic              rd_valid_ff;
   logic [COL_W-1:0]  col_d_ff;
   logic              last_d_ff;
   logic              panel_enable_ff;
   logic              blank_request_ff;

   logic              rsp_valid_ff;
   logic [COLUMN_W-1:0]   rsp_column_ff;
   logic [5:0]            rsp_bits_ff;
   logic [ROW_ADDR_W-1:0] rsp_row_address_ff;
   logic                  rsp_latch_last_ff;
   logic                  rsp_output_enable_ff;

   logic              x_ok, y_upper, y_lower;
   logic [ROW_W-1:0]  wr_row;
   logic [RAM_AW-1:0] wr_addr, pix_addr, rd_addr;
   logic [COLOR_W-1:0] wr_data, upper_px, lower_px;
   logic              we_upper, we_lower;
   logic [CMP_W-1:0]  lvl;
   logic [ROW_ADDR_W-1:0] row4;
   logic [5:0]        bits;

   // pixel write decode
   assign x_ok    = 32'(req_pixel_x) < PANEL_WIDTH;
   assign y_upper = 32'(req_pixel_y) < HALF_ROWS;
   assign y_lower = !y_upper && (32'(req_pixel_y) < 2 * HALF_ROWS);
   assign wr_row  = y_upper ? ROW_W'(req_pixel_y) : ROW_W'(32'(req_pixel_y) - HALF_ROWS);
   assign pix_addr = RAM_AW'({wr_row, COL_W'(req_pixel_x)});

   assign wr_addr  = cmd.clear_wr ? clr_ff : pix_addr;
   assign wr_data  = cmd.clear_wr ? '0 : req_pixel_color;
   assign we_upper = cmd.clear_wr || (cmd.pix_wr && x_ok && y_upper);
   assign we_lower = cmd.clear_wr || (cmd.pix_wr && x_ok && y_lower);
   assign rd_addr  = RAM_AW'({row_ff, col_ff});

   rmsd_ram #(.WIDTH(COLOR_W), .DEPTH(RAM_DEPTH)) u_ram_upper (
      .clock   (clock),
      .wr_en   (we_upper),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (upper_px)
   );

   rmsd_ram #(.WIDTH(COLOR_W), .DEPTH(RAM_DEPTH)) u_ram_lower (
      .clock   (clock),
      .wr_en   (we_lower),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (lower_px)
   );

   // counters and scan position
   always_comb begin
      clr_in   = cmd.clear_wr ? clr_ff + 1'b1 : clr_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      level_in = level_ff;
      if (cmd.rd_en) begin
         col_in = status.col_last ? '0 : col_ff + 1'b1;
      end
      if (cmd.row_step) begin
         if (row_ff == ROW_W'(HALF_ROWS - 1)) begin
            row_in   = '0;
            level_in = (level_ff == LVL_W'(LEVEL_STEPS - 1)) ? '0 : level_ff + 1'b1;
         end else begin
            row_in = row_ff + 1'b1;
         end
      end
   end

   assign status.clear_last = (clr_ff == RAM_AW'(RAM_DEPTH - 1));
   assign status.col_last   = (col_ff == COL_W'(PANEL_WIDTH - 1));
   assign status.pipe_busy  = rd_valid_ff || rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff           <= '0;
         col_ff           <= '0;
         row_ff           <= '0;
         level_ff         <= '0;
         rd_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         panel_enable_ff  <= 1'b0;
         blank_request_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         level_ff     <= level_in;
         rd_valid_ff  <= cmd.rd_en;
         rsp_valid_ff <= rd_valid_ff;
         if (csr_valid) begin
            case (csr_index)
               CSR_PANEL_ENABLE:  panel_enable_ff  <= csr_data;
               CSR_BLANK_REQUEST: blank_request_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // level compare
   assign lvl  = CMP_W'(level_ff);
   assign row4 = ROW_ADDR_W'(row_ff);
   assign bits = {CMP_W'(upper_px[7:5]) > lvl, CMP_W'(upper_px[4:2]) > lvl,
                  CMP_W'(upper_px[1:0]) > lvl, CMP_W'(lower_px[7:5]) > lvl,
                  CMP_W'(lower_px[4:2]) > lvl, CMP_W'(lower_px[1:0]) > lvl};

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         col_d_ff  <= col_ff;
         last_d_ff <= status.col_last;
      end
      if (rd_valid_ff) begin
         rsp_column_ff        <= COLUMN_W'(col_d_ff);
         rsp_bits_ff          <= bits;
         rsp_row_address_ff   <= last_d_ff ? {row4[0], row4[1], row4[2], row4[3]} : '0;
         rsp_latch_last_ff    <= last_d_ff;
         rsp_output_enable_ff <= panel_enable_ff && !blank_request_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_column        = rsp_column_ff;
   assign rsp_red_upper     = rsp_bits_ff[5];
   assign rsp_green_upper   = rsp_bits_ff[4];
   assign rsp_blue_upper    = rsp_bits_ff[3];
   assign rsp_red_lower     = rsp_bits_ff[2];
   assign rsp_green_lower   = rsp_bits_ff[1];
   assign rsp_blue_lower    = rsp_bits_ff[0];
   assign rsp_row_address   = rsp_row_address_ff;
   assign rsp_latch_last    = rsp_latch_last_ff;
   assign rsp_output_enable = rsp_output_enable_ff;

endmodule

FILE: rtl/rgb_matrix_scan_driver_core.sv
// ---------------------------------------------------------------------------
// rgb_matrix_scan_driver_core
// Scan driver for a HUB75 style RGB LED panel with half-height row scan.
// ---------------------------------------------------------------------------
// A pixel write (req_command = 0) leaves busy low. A scan (req_command = 1)
// keeps busy high through one frame buffer read per column from the two
// half-panel banks, a read register and a result register, then the row and
// gray level step. Results come one per cycle on rsp_valid, column 0 first,
// through the read and result registers; rsp_valid is a one-cycle strobe and
// the receiver must take every result as it appears. After reset busy is high
// while the frame buffer is cleared to black; csr writes are taken at any
// time, csr_ready is always high.
// ---------------------------------------------------------------------------
module rgb_matrix_scan_driver_core #(
   parameter int PANEL_WIDTH  = 64,
   parameter int PANEL_HEIGHT = 32,
   parameter int LEVEL_STEPS  = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_command,
   input  logic [rmsd_pkg::PIXEL_X_W-1:0]      req_pixel_x,
   input  logic [rmsd_pkg::PIXEL_Y_W-1:0]      req_pixel_y,
   input  logic [rmsd_pkg::COLOR_W-1:0]        req_pixel_color,
   output logic                                rsp_valid,
   output logic [rmsd_pkg::COLUMN_W-1:0]       rsp_column,
   output logic                                rsp_red_upper,
   output logic                                rsp_green_upper,
   output logic                                rsp_blue_upper,
   output logic                                rsp_red_lower,
   output logic                                rsp_green_lower,
   output logic                                rsp_blue_lower,
   output logic [rmsd_pkg::ROW_ADDR_W-1:0]     rsp_row_address,
   output logic                                rsp_latch_last,
   output logic                                rsp_output_enable,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rmsd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic                                csr_data
);

   import rmsd_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   rmsd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   rmsd_datapath #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT),
      .LEVEL_STEPS  (LEVEL_STEPS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_valid         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .req_pixel_color   (req_pixel_color),
      .rsp_valid         (rsp_valid),
      .rsp_column        (rsp_column),
      .rsp_red_upper     (rsp_red_upper),
      .rsp_green_upper   (rsp_green_upper),
      .rsp_blue_upper    (rsp_blue_upper),
      .rsp_red_lower     (rsp_red_lower),
      .rsp_green_lower   (rsp_green_lower),
      .rsp_blue_lower    (rsp_blue_lower),
      .rsp_row_address   (rsp_row_address),
      .rsp_latch_last    (rsp_latch_last),
      .rsp_output_enable (rsp_output_enable)
   );

`ifndef ASSERT_OFF
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result item outside a scan");

   a_latch_ends_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_latch_last |=> !rsp_valid)
      else $error("result item after latch");

   a_row_addr_on_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_latch_last |-> rsp_row_address == '0)
      else $error("row address off the last column");

   a_column_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_latch_last |=>
         rsp_valid && rsp_column == COLUMN_W'($past(rsp_column) + 1'b1))
      else $error("column sequence broken");

   a_scan_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == CMD_SCAN |=> busy)
      else $error("scan accepted without busy");
`endif

endmodule

FILE: test/rgb_matrix_scan_driver_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb_matrix_scan_driver_core_tb
// ---------------------------------------------------------------------------
// Self-checking bench for the RGB panel scan driver. A local frame buffer
// model follows every pixel write and every row scan. For each scan it
// predicts the 64 column groups: the colour bits against the gray level,
// the latch flag and the reversed row address on the last column, and the
// output enable. The stimulus is a short directed set (corners, channel
// extremes, off-panel writes, unused fields on scans). Random items follow
// over several enable/blank settings and sender gap rates. Most random
// writes target the row pair that the next scan reads, so the results are
// not all black. The scans run through every gray level.
// ---------------------------------------------------------------------------
module rgb_matrix_scan_driver_core_tb;
   import rmsd_pkg::*;

   localparam int PANEL_W      = 64;
   localparam int PANEL_H      = 32;
   localparam int HALF_H       = PANEL_H / 2;
   localparam int LEVELS       = 9;
   localparam int RANDOM_ITEMS = 110;
   localparam int NUM_PHASES   = 5;
   localparam int CYCLE_LIMIT  = 200000;

   // register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct {
      logic                 command;
      logic [PIXEL_X_W-1:0] x;
      logic [PIXEL_Y_W-1:0] y;
      logic [COLOR_W-1:0]   color;
      bit                   wait_drained;
   } panel_item_type;

   typedef struct {
      logic [COLUMN_W-1:0]   column;
      logic                  red_upper;
      logic                  green_upper;
      logic                  blue_upper;
      logic                  red_lower;
      logic                  green_lower;
      logic                  blue_lower;
      logic [ROW_ADDR_W-1:0] row_address;
      logic                  latch_last;
      logic                  output_enable;
   } column_bits_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic                  req_command     = CMD_PIXEL_WRITE;
   logic [PIXEL_X_W-1:0]  req_pixel_x     = '0;
   logic [PIXEL_Y_W-1:0]  req_pixel_y     = '0;
   logic [COLOR_W-1:0]    req_pixel_color = '0;
   logic                  rsp_valid;
   logic [COLUMN_W-1:0]   rsp_column;
   logic                  rsp_red_upper;
   logic                  rsp_green_upper;
   logic                  rsp_blue_upper;
   logic                  rsp_red_lower;
   logic                  rsp_green_lower;
   logic                  rsp_blue_lower;
   logic [ROW_ADDR_W-1:0] rsp_row_address;
   logic                  rsp_latch_last;
   logic                  rsp_output_enable;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic                  csr_data  = 1'b0;

   rgb_matrix_scan_driver_core uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .req_pixel_color(req_pixel_color),
      .rsp_valid(rsp_valid),
      .rsp_column(rsp_column),
      .rsp_red_upper(rsp_red_upper),
      .rsp_green_upper(rsp_green_upper),
      .rsp_blue_upper(rsp_blue_upper),
      .rsp_red_lower(rsp_red_lower),
      .rsp_green_lower(rsp_green_lower),
      .rsp_blue_lower(rsp_blue_lower),
      .rsp_row_address(rsp_row_address),
      .rsp_latch_last(rsp_latch_last),
      .rsp_output_enable(rsp_output_enable),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // panel model
   logic [COLOR_W-1:0]    frame_pixels [PANEL_W*PANEL_H];
   logic [3:0]            scan_row   = '0;
   logic [3:0]            gray_level = '0;
   logic                  panel_en   = 1'b0;
   logic                  blank_req  = 1'b0;
   logic [LEVELS-1:0]     levels_seen = '0;

   panel_item_type  pending_items [$];
   column_bits_type expected_columns [$];

   int  sender_idle_pct = 0;
   int  gen_scans = 0;
   int  gen_items = 0;
   int  mismatches = 0;
   int  columns_checked = 0;
   int  scans_taken = 0;
   int  writes_taken = 0;
   int  writes_off_panel = 0;
   int  cycle_count = 0;
   logic item_taken = 1'b0;
   logic csr_taken  = 1'b0;
   panel_item_type next_item;

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         mismatches++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   task automatic check_column();
      column_bits_type want;
      if (expected_columns.size() == 0) begin
         mismatches++;
         $error("column %0d arrived with nothing expected", rsp_column);
      end else begin
         want = expected_columns.pop_front();
         columns_checked++;
         check_field("column", want.column, rsp_column);
         check_field("red_upper", want.red_upper, rsp_red_upper);
         check_field("green_upper", want.green_upper, rsp_green_upper);
         check_field("blue_upper", want.blue_upper, rsp_blue_upper);
         check_field("red_lower", want.red_lower, rsp_red_lower);
         check_field("green_lower", want.green_lower, rsp_green_lower);
         check_field("blue_lower", want.blue_lower, rsp_blue_lower);
         check_field("row_address", want.row_address, rsp_row_address);
         check_field("latch_last", want.latch_last, rsp_latch_last);
         check_field("output_enable", want.output_enable, rsp_output_enable);
      end
   endtask

   task automatic predict_scan();
      column_bits_type c;
      logic [COLOR_W-1:0] up;
      logic [COLOR_W-1:0] lo;
      bit last;
      levels_seen[gray_level] = 1'b1;
      for (int col = 0; col < PANEL_W; col++) begin
         up = frame_pixels[int'(scan_row) * PANEL_W + col];
         lo = frame_pixels[(int'(scan_row) + HALF_H) * PANEL_W + col];
         last = (col == PANEL_W - 1);
         c.column        = col[COLUMN_W-1:0];
         c.red_upper     = {1'b0, up[7:5]} > gray_level;
         c.green_upper   = {1'b0, up[4:2]} > gray_level;
         c.blue_upper    = {2'b00, up[1:0]} > gray_level;
         c.red_lower     = {1'b0, lo[7:5]} > gray_level;
         c.green_lower   = {1'b0, lo[4:2]} > gray_level;
         c.blue_lower    = {2'b00, lo[1:0]} > gray_level;
         c.row_address   = last ? {scan_row[0], scan_row[1], scan_row[2], scan_row[3]} : '0;
         c.latch_last    = last;
         c.output_enable = panel_en & ~blank_req;
         expected_columns.push_back(c);
      end
      if (int'(scan_row) == HALF_H - 1) begin
         scan_row = '0;
         gray_level = (int'(gray_level) == LEVELS - 1) ? '0 : gray_level + 4'd1;
      end else begin
         scan_row = scan_row + 4'd1;
      end
   endtask

   task automatic apply_item(logic cmd, logic [PIXEL_X_W-1:0] x, logic [PIXEL_Y_W-1:0] y,
                             logic [COLOR_W-1:0] color);
      if (cmd == CMD_SCAN) begin
         scans_taken++;
         predict_scan();
      end else begin
         writes_taken++;
         if (x < PANEL_W && y < PANEL_H)
            frame_pixels[int'(y) * PANEL_W + int'(x)] = color;
         else
            writes_off_panel++;
      end
   endtask

   // monitor and predictor
   always @(posedge clock) begin
      item_taken <= !reset && start && !busy;
      csr_taken  <= !reset && csr_valid && csr_ready;
      if (!reset) begin
         if (rsp_valid)
            check_column();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PANEL_ENABLE:  panel_en  = csr_data;
               CSR_BLANK_REQUEST: blank_req = csr_data;
               default: ;
            endcase
         end
         if (start && !busy)
            apply_item(req_command, req_pixel_x, req_pixel_y, req_pixel_color);
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || item_taken) begin
         if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
             !(pending_items[0].wait_drained && expected_columns.size() != 0)) begin
            next_item = pending_items.pop_front();
            start           <= 1'b1;
            req_command     <= next_item.command;
            req_pixel_x     <= next_item.x;
            req_pixel_y     <= next_item.y;
            req_pixel_color <= next_item.color;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic queue_item(logic cmd, int x, int y, int color, bit wait_drained = 0);
      panel_item_type it;
      it.command      = cmd;
      it.x            = x[PIXEL_X_W-1:0];
      it.y            = y[PIXEL_Y_W-1:0];
      it.color        = color[COLOR_W-1:0];
      it.wait_drained = wait_drained;
      pending_items.push_back(it);
      gen_items++;
      if (cmd == CMD_SCAN)
         gen_scans++;
   endtask

   task automatic queue_random_item(bit wait_drained);
      int pick;
      int row;
      int color;
      pick = $urandom_range(99);
      row  = gen_scans % HALF_H;
      color = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                       : $urandom_range(255);
      if (pick < 38)
         queue_item(CMD_SCAN, $urandom_range(127), $urandom_range(63), color, wait_drained);
      else if (pick < 85)
         queue_item(CMD_PIXEL_WRITE, $urandom_range(PANEL_W - 1),
                    $urandom_range(1) ? row : row + HALF_H, color, wait_drained);
      else
         queue_item(CMD_PIXEL_WRITE, $urandom_range(127), $urandom_range(63), color,
                    wait_drained);
   endtask

   // called at a falling edge; returns at the falling edge after the write
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(negedge clock); while (!csr_taken);
   endtask

   task automatic program_panel(logic enable, logic blank);
      @(negedge clock);
      csr_write(CSR_PANEL_ENABLE, enable);
      csr_write(CSR_BLANK_REQUEST, blank);
      csr_write(CSR_SPARE_2, 1'($urandom_range(1)));
      csr_write(CSR_SPARE_3, 1'($urandom_range(1)));
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      while (scans_taken + writes_taken != gen_items) @(negedge clock);
      while (expected_columns.size() != 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   logic phase_enable [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
   logic phase_blank  [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
   int   phase_idle   [NUM_PHASES] = '{0, 0, 61, 16, 61};

   initial begin
      for (int i = 0; i < PANEL_W * PANEL_H; i++)
         frame_pixels[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);
      while (busy) @(negedge clock);

      for (int p = 0; p < NUM_PHASES; p++) begin
         program_panel(phase_enable[p], phase_blank[p]);
         sender_idle_pct = phase_idle[p];
         if (p == 0) begin
            queue_item(CMD_SCAN, 0, 0, 0);
            queue_item(CMD_PIXEL_WRITE, 0, 0, 8'hFF);
            queue_item(CMD_PIXEL_WRITE, 63, 0, 8'hE0);
            queue_item(CMD_PIXEL_WRITE, 31, 0, 8'h1C);
            queue_item(CMD_PIXEL_WRITE, 1, 0, 8'h03);
            queue_item(CMD_PIXEL_WRITE, 0, 16, 8'hFF);
            queue_item(CMD_PIXEL_WRITE, 63, 16, 8'h02);
            queue_item(CMD_PIXEL_WRITE, 2, 16, 8'h01);
            // off-panel writes, must not land anywhere
            queue_item(CMD_PIXEL_WRITE, 64, 0, 8'hFF);
            queue_item(CMD_PIXEL_WRITE, 127, 1, 8'hFF);
            queue_item(CMD_PIXEL_WRITE, 0, 32, 8'hFF);
            queue_item(CMD_PIXEL_WRITE, 5, 63, 8'hFF);
            // pixel fields set on a scan are don't-care
            queue_item(CMD_SCAN, 127, 63, 8'hFF);
            queue_item(CMD_PIXEL_WRITE, 0, 1, 8'hFF);
            queue_item(CMD_PIXEL_WRITE, 0, 1, 8'h00);
            queue_item(CMD_PIXEL_WRITE, 63, 17, 8'hB6);
            queue_item(CMD_PIXEL_WRITE, 63, 31, 8'hFF);
            queue_item(CMD_PIXEL_WRITE, 0, 15, 8'hFF);
            queue_item(CMD_SCAN, 85, 42, 8'hAA);
            queue_item(CMD_SCAN, 42, 21, 8'h55);
         end else begin
            for (int i = 0; i < RANDOM_ITEMS; i++)
               queue_random_item((p == 1 && i == 50) || $urandom_range(99) < 4);
         end
         wait_idle();
      end

      $display("Checked %0d columns from %0d scans; %0d pixel writes, %0d of them off-panel",
               columns_checked, scans_taken, writes_taken, writes_off_panel);
      $display("Gray levels scanned: %0d of %0d, over %0d enable/blank settings",
               $countones(levels_seen), LEVELS, NUM_PHASES);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
